[design/hbbl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbbl_pkg
// Shared types and constants of the hashed bigram bias learner.
// ----------------------------------------------------------------------------
package hbbl_pkg;

  localparam int TABLE_DEPTH = 4096;

  localparam int TOKEN_W = 16;
  localparam int POS_W   = 16;
  localparam int SIZE_W  = 13;
  localparam int BIAS_W  = 8;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 12;
  localparam int CNT_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int HASH_W  = 64;
  localparam int DIGIT_W = 16;

  localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT = 33;

  localparam logic [TOKEN_W-1:0] LOW_TOKEN_BOUND  = 16'd3;
  localparam logic [TOKEN_W-1:0] HIGH_TOKEN_BOUND = 16'd1000;
  localparam logic [TOKEN_W-1:0] CLOSE_DISTANCE   = 16'd50;

  localparam logic           RST_LEARN_ENABLE  = 1'b1;
  localparam logic [POS_W-1:0] RST_PROMPT_LENGTH = '0;
  localparam logic [SIZE_W-1:0] RST_TABLE_ENTRIES = 13'd4096;
  localparam logic [BIAS_W-1:0] RST_BIAS_STEP  = 8'd100;
  localparam logic [BIAS_W-1:0] RST_BIAS_LIMIT = 8'd200;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_ENABLE  = 3'd0,
    REG_PROMPT_LENGTH = 3'd1,
    REG_TABLE_ENTRIES = 3'd2,
    REG_BIAS_STEP     = 3'd3,
    REG_BIAS_LIMIT    = 3'd4
  } cfg_reg_t;

  typedef enum logic [STAT_W-1:0] {
    ST_IDLE      = 3'd0,
    ST_FILTERED  = 3'd1,
    ST_UPDATED   = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_OFF,
    K_FILTERED,
    K_LEARN
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MIX,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [TOKEN_W-1:0] prev;
    logic [TOKEN_W-1:0] tgt;
    logic [SIZE_W-1:0]  start;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [BIAS_W-1:0]  bias;
    logic [CNT_W-1:0]   count;
  } result_t;

  function automatic logic [DIGIT_W-1:0] mix_digit(input logic sel, input logic [1:0] dig);
    logic [HASH_W-1:0] c;
    c = sel ? MIX_MUL_B : MIX_MUL_A;
    return c[dig*DIGIT_W +: DIGIT_W];
  endfunction

  function automatic logic lacks_substance(input logic [TOKEN_W-1:0] prev,
                                           input logic [TOKEN_W-1:0] tgt);
    logic [TOKEN_W-1:0] diff;
    diff = (prev > tgt) ? prev - tgt : tgt - prev;
    if (prev < LOW_TOKEN_BOUND || tgt < LOW_TOKEN_BOUND) return 1'b1;
    if (prev == tgt) return 1'b1;
    if (prev > HIGH_TOKEN_BOUND && tgt > HIGH_TOKEN_BOUND && diff < CLOSE_DISTANCE)
      return 1'b1;
    return 1'b0;
  endfunction

endpackage
`default_nettype wire

[design/hbbl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbbl_front
// Accepts transitions, classifies them and hashes kept keys to a start slot.
// ----------------------------------------------------------------------------
module hbbl_front
  import hbbl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  hold,
  input  wire logic                  learn_enable,
  input  wire logic [POS_W-1:0]      prompt_length,
  input  wire logic [SIZE_W-1:0]     size,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [POS_W-1:0]      position,
  input  wire logic [TOKEN_W-1:0]    previous_token,
  input  wire logic [TOKEN_W-1:0]    tgt_token,
  output      logic                  push,
  output      request_t              push_req,
  input  wire logic                  queue_full
);

  front_state_t        state_r, state_nxt;
  request_t            req_r, req_nxt;
  logic [HASH_W-1:0]   x_r, x_nxt;
  logic [HASH_W-1:0]   acc_r, acc_nxt;
  logic                sel_r, sel_nxt;
  logic [1:0]          dig_r, dig_nxt;
  logic [3:0]          nib_r, nib_nxt;
  logic [SIZE_W-1:0]   rem_r, rem_nxt;

  logic [TOKEN_W-1:0]  prev_eff;
  logic [HASH_W-1:0]   h0;
  logic [HASH_W-1:0]   prod;
  logic [HASH_W-1:0]   acc_sum;
  logic [SIZE_W:0]     r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid && !hold) state_nxt = (req_nxt.kind == K_LEARN) ? F_MIX : F_PUSH;
      F_MIX:  if (sel_r && dig_r == 2'd3) state_nxt = F_MOD;
      F_MOD:  if (nib_r == 4'd15) state_nxt = F_PUSH;
      F_PUSH: if (!queue_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    prev_eff = (position == '0) ? TOKEN_W'(1) : previous_token;
    h0       = HASH_W'(prev_eff);
    prod     = x_r * HASH_W'(mix_digit(sel_r, dig_r));
    acc_sum  = acc_r + (prod << (DIGIT_W * dig_r));
    req_nxt  = req_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    sel_nxt  = sel_r;
    dig_nxt  = dig_r;
    nib_nxt  = nib_r;
    rem_nxt  = rem_r;
    r        = '0;
    in_ready = (state_r == F_IDLE) && !hold;
    push     = (state_r == F_PUSH) && !queue_full;
    push_req = req_r;
    unique case (state_r)
      F_IDLE: begin
        req_nxt.prev  = prev_eff;
        req_nxt.tgt   = tgt_token;
        req_nxt.start = '0;
        if (!learn_enable || position < prompt_length) req_nxt.kind = K_OFF;
        else if (lacks_substance(prev_eff, tgt_token)) req_nxt.kind = K_FILTERED;
        else req_nxt.kind = K_LEARN;
        x_nxt   = h0 ^ (h0 >> MIX_SHIFT);
        acc_nxt = '0;
        sel_nxt = 1'b0;
        dig_nxt = '0;
        nib_nxt = '0;
        rem_nxt = '0;
      end
      F_MIX: begin
        dig_nxt = dig_r + 2'd1;
        acc_nxt = acc_sum;
        if (dig_r == 2'd3) begin
          x_nxt   = acc_sum ^ (acc_sum >> MIX_SHIFT);
          acc_nxt = '0;
          sel_nxt = 1'b1;
        end
      end
      F_MOD: begin
        r = {1'b0, rem_r};
        for (int j = 0; j < 4; j++) begin
          r = {r[SIZE_W-1:0], x_r[HASH_W-1-j]};
          if (r >= {1'b0, size}) r = r - {1'b0, size};
        end
        rem_nxt = r[SIZE_W-1:0];
        x_nxt   = x_r << 4;
        nib_nxt = nib_r + 4'd1;
        if (nib_r == 4'd15) req_nxt.start = r[SIZE_W-1:0];
      end
      F_PUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    req_r <= req_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    sel_r <= sel_nxt;
    dig_r <= dig_nxt;
    nib_r <= nib_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire

[design/hbbl_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbbl_queue
// Short request queue between the classify front and the table back.
// ----------------------------------------------------------------------------
module hbbl_queue
  import hbbl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire request_t push_req,
  output      logic     full,
  input  wire logic     pop,
  output      request_t pop_req,
  output      logic     empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  request_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_r, rd_r;
  logic [PTR_W:0]       fill_r;

  assign full    = (fill_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_req = slots_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) fill_r <= fill_r + 1'b1;
      else if (pop && !push) fill_r <= fill_r - 1'b1;
    end
    if (push) slots_r[wr_r] <= push_req;
  end

endmodule
`default_nettype wire

[design/hbbl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbbl_back
// Clears the slot table after reset, probes it and holds the result register.
// ----------------------------------------------------------------------------
module hbbl_back
  import hbbl_pkg::*;
#(
  parameter int PROBE_LIMIT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SIZE_W-1:0] size,
  input  wire logic [BIAS_W-1:0] bias_step,
  input  wire logic [BIAS_W-1:0] bias_limit,
  input  wire logic              q_empty,
  input  wire request_t          q_req,
  output      logic              q_pop,
  output      logic              clearing,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      result_t           out_res
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PRB_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

  logic [TOKEN_W-1:0] key_mem  [TABLE_DEPTH];
  logic [TOKEN_W-1:0] pred_mem [TABLE_DEPTH];
  logic [BIAS_W-1:0]  bias_mem [TABLE_DEPTH];

  back_state_t        state_r, state_nxt;
  request_t           req_r, req_nxt;
  logic [SIZE_W-1:0]  cur_r, cur_nxt;
  logic [PRB_W-1:0]   prb_r, prb_nxt;
  logic [IDX_W-1:0]   clr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  result_t            res_r, res_nxt;
  result_t            out_r;
  logic               out_valid_r;
  logic [TOKEN_W-1:0] key_q;
  logic [BIAS_W-1:0]  bias_q;

  logic               key_we, bias_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [TOKEN_W-1:0] key_wd;
  logic [BIAS_W-1:0]  bias_wd;
  logic [BIAS_W:0]    sum;
  logic [BIAS_W-1:0]  nb;
  logic               out_load;

  assign clearing  = (state_r == B_CLEAR);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign out_load  = (state_r == B_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: if (clr_r == {IDX_W{1'b1}}) state_nxt = B_IDLE;
      B_IDLE:  if (!q_empty) state_nxt = (q_req.kind == K_LEARN) ? B_READ : B_DONE;
      B_READ:  state_nxt = B_CHECK;
      B_CHECK: begin
        if (key_q == req_r.prev || key_q == '0 || prb_r == PRB_W'(PROBE_LIMIT - 1))
          state_nxt = B_DONE;
        else
          state_nxt = B_READ;
      end
      B_DONE:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    req_nxt = req_r;
    cur_nxt = cur_r;
    prb_nxt = prb_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    q_pop   = 1'b0;
    key_we  = 1'b0;
    bias_we = 1'b0;
    wr_addr = IDX_W'(cur_r);
    key_wd  = req_r.prev;
    bias_wd = bias_step;
    sum     = {1'b0, bias_q} + {1'b0, bias_step};
    nb      = (sum > {1'b0, bias_limit}) ? bias_limit : sum[BIAS_W-1:0];
    unique case (state_r)
      B_CLEAR: begin
        key_we  = 1'b1;
        wr_addr = clr_r;
        key_wd  = '0;
      end
      B_IDLE: begin
        q_pop   = !q_empty;
        req_nxt = q_req;
        cur_nxt = q_req.start;
        prb_nxt = '0;
        res_nxt = '{status: (q_req.kind == K_OFF) ? ST_IDLE : ST_FILTERED,
                    slot: '0, bias: '0, count: cnt_r};
        if (q_req.kind == K_LEARN) res_nxt.status = ST_EXHAUSTED;
      end
      B_READ: ;
      B_CHECK: begin
        if (key_q == req_r.prev) begin
          bias_we = 1'b1;
          bias_wd = nb;
          res_nxt = '{status: ST_UPDATED, slot: SLOT_W'(cur_r), bias: nb, count: cnt_r};
        end else if (key_q == '0) begin
          key_we  = 1'b1;
          bias_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          res_nxt = '{status: ST_INSERTED, slot: SLOT_W'(cur_r), bias: bias_step,
                      count: cnt_r + 1'b1};
        end else begin
          prb_nxt = prb_r + 1'b1;
          cur_nxt = (cur_r + 1'b1 == size) ? '0 : cur_r + 1'b1;
        end
      end
      B_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= key_wd;
    if (key_we && state_r == B_CHECK) pred_mem[wr_addr] <= req_r.tgt;
    if (bias_we) bias_mem[wr_addr] <= bias_wd;
    key_q  <= key_mem[IDX_W'(cur_r)];
    bias_q <= bias_mem[IDX_W'(cur_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == B_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    req_r <= req_nxt;
    cur_r <= cur_nxt;
    prb_r <= prb_nxt;
    res_r <= res_nxt;
    if (out_load) out_r <= res_r;
  end

endmodule
`default_nettype wire

[design/hashed_bigram_bias_learner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_bigram_bias_learner
// Learns bigram biases in an open-addressed hash table with linear probing.
// ----------------------------------------------------------------------------
// After reset the key table is swept to empty, one slot a cycle; no request is
// taken until then. A learned request runs the 64x16 partial products of the
// two finalizer multiplies, then the modulo by the table size at four bits a
// cycle, then a registered table read and a compare for each slot probed, up
// to PROBE_LIMIT slots. Requests that are switched off or filtered skip the
// hash and the probe. The front may hash the next request while the back
// probes the current one.
module hashed_bigram_bias_learner
  import hbbl_pkg::*;
#(
  parameter int PROBE_LIMIT = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // position, previous_token, target_token
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // status, slot_index, bias_value, entry_count, zero fill
  output      logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic               learn_enable_r;
  logic [POS_W-1:0]   prompt_length_r;
  logic [SIZE_W-1:0]  table_entries_r;
  logic [BIAS_W-1:0]  bias_step_r;
  logic [BIAS_W-1:0]  bias_limit_r;
  logic [SIZE_W-1:0]  size;

  logic     push, full, pop, empty, clearing;
  request_t push_req, pop_req;
  result_t  res;

  always_comb begin
    if (table_entries_r == '0) size = SIZE_W'(1);
    else if (32'(table_entries_r) > TABLE_DEPTH) size = SIZE_W'(TABLE_DEPTH);
    else size = table_entries_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_enable_r  <= RST_LEARN_ENABLE;
      prompt_length_r <= RST_PROMPT_LENGTH;
      table_entries_r <= RST_TABLE_ENTRIES;
      bias_step_r     <= RST_BIAS_STEP;
      bias_limit_r    <= RST_BIAS_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEARN_ENABLE:  learn_enable_r  <= cfg_wdata[0];
        REG_PROMPT_LENGTH: prompt_length_r <= cfg_wdata[POS_W-1:0];
        REG_TABLE_ENTRIES: table_entries_r <= cfg_wdata[SIZE_W-1:0];
        REG_BIAS_STEP:     bias_step_r     <= cfg_wdata[BIAS_W-1:0];
        REG_BIAS_LIMIT:    bias_limit_r    <= cfg_wdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  hbbl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (clearing),
    .learn_enable   (learn_enable_r),
    .prompt_length  (prompt_length_r),
    .size           (size),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .position       (in_tdata[15:0]),
    .previous_token (in_tdata[31:16]),
    .tgt_token      (in_tdata[47:32]),
    .push           (push),
    .push_req       (push_req),
    .queue_full     (full)
  );

  hbbl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (full),
    .pop      (pop),
    .pop_req  (pop_req),
    .empty    (empty)
  );

  hbbl_back #(
    .PROBE_LIMIT (PROBE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .size       (size),
    .bias_step  (bias_step_r),
    .bias_limit (bias_limit_r),
    .q_empty    (empty),
    .q_req      (pop_req),
    .q_pop      (pop),
    .clearing   (clearing),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {4'b0, res.count, res.bias, res.slot, res.status};

endmodule
`default_nettype wire

[verif/hashed_bigram_bias_learner_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_bigram_bias_learner_test
// Self-checking bench for the bigram bias learner. A directed table of token
// transitions is followed by random phases under several register settings.
// Every result is checked field by field against its directed row or a model
// of the linear-probing hash table; several phases idle both sides at random.
// ----------------------------------------------------------------------------
module hashed_bigram_bias_learner_test;
  import hbbl_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int PROBES      = 8;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [POS_W-1:0]   pos;
    logic [TOKEN_W-1:0] prev;
    logic [TOKEN_W-1:0] tgt;
    bit                 typed;
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [BIAS_W-1:0]  bias;
    logic [CNT_W-1:0]   count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hashed_bigram_bias_learner dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // model copy of the table and registers
  logic               learn_on;
  logic [POS_W-1:0]   prompt_cfg;
  logic [SIZE_W-1:0]  entries_cfg;
  logic [BIAS_W-1:0]  step_cfg;
  logic [BIAS_W-1:0]  limit_cfg;
  logic [TOKEN_W-1:0] key_mem [DEPTH];
  logic [BIAS_W-1:0]  bias_mem [DEPTH];
  logic [CNT_W-1:0]   occupied;

  result_t pending_results[$];
  int errors = 0;
  int requests = 0;
  int status_seen [5];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  logic [TOKEN_W-1:0] token_pool [48];

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [HASH_W-1:0] finalize64(input logic [HASH_W-1:0] h);
    h = h ^ (h >> MIX_SHIFT);
    h = h * 64'hff51afd7ed558ccd;
    h = h ^ (h >> MIX_SHIFT);
    h = h * 64'hc4ceb9fe1a85ec53;
    h = h ^ (h >> MIX_SHIFT);
    return h;
  endfunction

  function automatic bit is_noise(input logic [TOKEN_W-1:0] p, input logic [TOKEN_W-1:0] t);
    logic [TOKEN_W-1:0] d;
    d = (p > t) ? p - t : t - p;
    if (p < 3 || t < 3) return 1'b1;
    if (p == t) return 1'b1;
    return (p > 1000 && t > 1000 && d < 50);
  endfunction

  task automatic learn_transition(input logic [POS_W-1:0] pos, input logic [TOKEN_W-1:0] prev_in,
                                  input logic [TOKEN_W-1:0] tgt, output result_t r);
    logic [TOKEN_W-1:0] prev;
    int size, first, cur, nb;
    prev = (pos == 0) ? 16'd1 : prev_in;
    r.status = ST_IDLE;
    r.slot = '0;
    r.bias = '0;
    if (learn_on && pos >= prompt_cfg) begin
      if (is_noise(prev, tgt)) begin
        r.status = ST_FILTERED;
      end else begin
        size = (entries_cfg == 0) ? 1 : ((entries_cfg > DEPTH) ? DEPTH : int'(entries_cfg));
        first = int'(finalize64({48'd0, prev}) % size);
        r.status = ST_EXHAUSTED;
        for (int i = 0; i < PROBES; i++) begin
          cur = (first + i) % size;
          if (key_mem[cur] == prev) begin
            nb = bias_mem[cur] + step_cfg;
            if (nb > limit_cfg) nb = limit_cfg;
            bias_mem[cur] = nb[BIAS_W-1:0];
            r.status = ST_UPDATED;
            r.slot = cur[SLOT_W-1:0];
            r.bias = nb[BIAS_W-1:0];
            break;
          end
          if (key_mem[cur] == 0) begin
            key_mem[cur] = prev;
            bias_mem[cur] = step_cfg;
            occupied = occupied + 1'b1;
            r.status = ST_INSERTED;
            r.slot = cur[SLOT_W-1:0];
            r.bias = step_cfg;
            break;
          end
        end
      end
    end
    r.count = occupied;
  endtask

  // receiver: random or held-off ready, checks at the rising edge
  initial begin
    int hold;
    result_t want;
    status_t got_st;
    logic [SLOT_W-1:0] got_slot;
    logic [BIAS_W-1:0] got_bias;
    logic [CNT_W-1:0] got_cnt;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got_st   = status_t'(out_tdata[2:0]);
        got_slot = out_tdata[14:3];
        got_bias = out_tdata[22:15];
        got_cnt  = out_tdata[35:23];
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending, got %h", $time, out_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got_st <= ST_EXHAUSTED) status_seen[got_st]++;
          if (got_st !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got_st);
            errors++;
          end
          if (got_slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got_slot);
            errors++;
          end
          if (got_bias !== want.bias) begin
            $display("%0t: bias expected %0d actual %0d", $time, want.bias, got_bias);
            errors++;
          end
          if (got_cnt !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, got_cnt);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_request(input logic [POS_W-1:0] pos, input logic [TOKEN_W-1:0] prev,
                              input logic [TOKEN_W-1:0] tgt, input bit typed,
                              input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {tgt, prev, pos};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    learn_transition(pos, prev, tgt, r);
    pending_results.push_back(typed ? typed_res : r);
    requests++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_LEARN_ENABLE:  learn_on = val[0];
      REG_PROMPT_LENGTH: prompt_cfg = val;
      REG_TABLE_ENTRIES: entries_cfg = val[SIZE_W-1:0];
      REG_BIAS_STEP:     step_cfg = val[BIAS_W-1:0];
      REG_BIAS_LIMIT:    limit_cfg = val[BIAS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_requests(input int n);
    logic [POS_W-1:0] pos;
    logic [TOKEN_W-1:0] prev, tgt;
    result_t none;
    none = '0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 75) begin
        // well-formed transition over a small vocabulary so keys repeat
        pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(200)) : POS_W'($urandom);
        prev = token_pool[$urandom_range(47)];
        tgt = token_pool[$urandom_range(47)];
        if (tgt == prev) tgt = tgt ^ 16'h0100;
      end else begin
        pos = POS_W'($urandom);
        prev = ($urandom_range(3) == 0) ? TOKEN_W'($urandom_range(4)) : TOKEN_W'($urandom);
        tgt = ($urandom_range(3) == 0) ? prev + TOKEN_W'($urandom_range(60)) : TOKEN_W'($urandom);
      end
      send_request(pos, prev, tgt, 1'b0, none);
    end
  endtask

  stim_row_t directed [15] = '{
    '{16'd0,     16'd500,   16'd600,   1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd2,     16'd600,   1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd600,   16'd2,     1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd700,   16'd700,   1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd1001,  16'd1049,  1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd65535, 16'd65534, 1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd65535, 16'd0,     1, ST_FILTERED, 12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd1001,  16'd1051,  0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd1051,  16'd1001,  0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd3,     16'd65535, 0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd3,     16'd4,     0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd3,     16'd4,     0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd5,     16'd3,     16'd9,     0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd65535, 16'd1000,  16'd1001,  0, ST_IDLE,     12'd0, 8'd0, 13'd0},
    '{16'd65535, 16'd65535, 16'd3,     0, ST_IDLE,     12'd0, 8'd0, 13'd0}
  };

  initial begin
    result_t typed_res;
    learn_on = RST_LEARN_ENABLE;
    prompt_cfg = RST_PROMPT_LENGTH;
    entries_cfg = RST_TABLE_ENTRIES;
    step_cfg = RST_BIAS_STEP;
    limit_cfg = RST_BIAS_LIMIT;
    occupied = '0;
    for (int i = 0; i < DEPTH; i++) begin
      key_mem[i] = '0;
      bias_mem[i] = '0;
    end
    for (int i = 0; i < 48; i++)
      token_pool[i] = (i < 24) ? TOKEN_W'($urandom_range(1100, 3)) : TOKEN_W'($urandom_range(65535, 3));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 26;
    recv_idle_pct = 81;
    foreach (directed[i]) begin
      typed_res = '{directed[i].status, directed[i].slot, directed[i].bias, directed[i].count};
      send_request(directed[i].pos, directed[i].prev, directed[i].tgt, directed[i].typed,
                   typed_res);
    end
    random_requests(280);

    drain();
    write_reg(REG_TABLE_ENTRIES, 16'd16);
    write_reg(REG_BIAS_STEP, 16'd255);
    write_reg(REG_PROMPT_LENGTH, 16'd100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 400;
    random_requests(60);
    send_idle_pct = 26;
    recv_idle_pct = 81;
    random_requests(240);

    // the other way round
    drain();
    write_reg(REG_TABLE_ENTRIES, 16'd0);
    write_reg(REG_BIAS_STEP, 16'd0);
    write_reg(REG_BIAS_LIMIT, 16'd255);
    write_reg(REG_PROMPT_LENGTH, 16'd0);
    send_idle_pct = 81;
    recv_idle_pct = 26;
    random_requests(150);

    drain();
    write_reg(REG_TABLE_ENTRIES, 16'h1fff);
    write_reg(REG_LEARN_ENABLE, 16'd0);
    random_requests(60);

    // neither side idles
    drain();
    write_reg(REG_LEARN_ENABLE, 16'd1);
    write_reg(REG_PROMPT_LENGTH, 16'd65535);
    write_reg(REG_TABLE_ENTRIES, 16'd100);
    write_reg(REG_BIAS_STEP, 16'd7);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(250);

    drain();
    write_reg(REG_PROMPT_LENGTH, 16'd0);
    write_reg(REG_TABLE_ENTRIES, 16'd4095);
    write_reg(REG_BIAS_STEP, 16'd100);
    write_reg(REG_BIAS_LIMIT, 16'd50);
    random_requests(300);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("%0d transitions over six register settings, table holds %0d keys", requests,
             occupied);
    $display("results off %0d filtered %0d updated %0d inserted %0d exhausted %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
